// ===== sv/qstd_pkg.sv =====
// Shared constants, types and helper functions for the smallest-three quaternion decoder.
package qstd_pkg;

  // Packed code layout.
  localparam int CODE_W     = 48;
  localparam int SIGN_BIT   = 47;
  localparam int INDEX_LSB  = 45;
  localparam int DROP_W     = 2;
  localparam int NFIELD     = 3;
  localparam int FIELD_BITS = 15;

  // Output format.
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W         = 18;

  // Component indexes carried by the dropped-index bits.
  localparam logic [DROP_W-1:0] IDX_X = 2'd0;
  localparam logic [DROP_W-1:0] IDX_Y = 2'd1;
  localparam logic [DROP_W-1:0] IDX_Z = 2'd2;
  localparam logic [DROP_W-1:0] IDX_W = 2'd3;

  // Field scaling: |v - MID| * RS2 / (MID * 2^SCALE_SH), rounded half up.
  localparam longint RS2_Q30  = 64'd759250125;
  localparam int     RS2_W    = 30;
  localparam longint MID      = (longint'(1) << (FIELD_BITS - 1)) - 1;
  localparam int     SCALE_SH = 30 - OUT_FRAC_BITS;
  localparam longint HALF_D   = MID << (SCALE_SH - 1);
  localparam longint DDIV     = MID << SCALE_SH;
  localparam longint QMAX     =
    ((longint'(1) << (FIELD_BITS - 1)) * RS2_Q30 + HALF_D) / DDIV;

  // Datapath widths.
  localparam int DMAG_W = FIELD_BITS;
  localparam int PROD_W = FIELD_BITS + RS2_W;
  localparam int Y_W    = PROD_W - SCALE_SH;
  localparam int LO_W   = FIELD_BITS - 1;
  localparam int Q0_W   = Y_W - LO_W;
  localparam int R_W    = ((Q0_W > LO_W) ? Q0_W : LO_W) + 1;
  localparam int QW     = $clog2(QMAX + 1);
  localparam int CORR_N = 1 + int'(QMAX / MID);
  localparam int SQ_W   = 2 * QW;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RAD_W  = 2 * OUT_FRAC_BITS + 2;
  localparam int CMP_W  = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam longint ONE_SQ = longint'(1) << (2 * OUT_FRAC_BITS);

  // Square root pipeline.
  localparam int ROOT_W    = OUT_FRAC_BITS + 1;
  localparam int REM_W     = OUT_FRAC_BITS + 3;
  localparam int ISQ_STEPS = RAD_W / 2;
  localparam int SGN_W     = (ROOT_W + 1 > OUT_W) ? ROOT_W + 1 : OUT_W;

  // Queue between front and back, and front pipeline depth.
  localparam int QDEPTH       = 8;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = QPTR_W + 1;
  localparam int FRONT_STAGES = 4;
  localparam int INFL_W       = $clog2(FRONT_STAGES + 1);

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY = ISQ_STEPS + 7;

  // Side information that rides along the front pipeline.
  typedef struct packed {
    logic [NFIELD-1:0] kneg;
    logic [DROP_W-1:0] drop;
    logic              sign;
  } qstd_meta_t;

  // One classified item, as it sits in the queue.
  typedef struct packed {
    logic [NFIELD-1:0][QW-1:0] kmag;
    logic [NFIELD-1:0]         kneg;
    logic [DROP_W-1:0]         drop;
    logic                      sign;
    logic                      clamp;
    logic [RAD_W-1:0]          rad;
  } qstd_item_t;

  // One beat moving between front, queue and back.
  typedef struct packed {
    logic       valid;
    qstd_item_t item;
  } qstd_beat_t;

  // State of one square root stage.
  typedef struct packed {
    qstd_item_t        item;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } qstd_root_t;

  // Sign a magnitude and keep the low OUT_W bits.
  function automatic logic [OUT_W-1:0] to_out(logic [ROOT_W-1:0] mag, logic neg);
    logic [SGN_W-1:0] ext;
    ext = SGN_W'(mag);
    if (neg) begin
      ext = -ext;
    end
    return ext[OUT_W-1:0];
  endfunction

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic qstd_root_t root_step(qstd_root_t s);
    qstd_root_t       n;
    logic [REM_W+1:0] wide;
    logic [REM_W+1:0] trial;
    n     = s;
    wide  = {s.rem, s.item.rad[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({s.root, 2'b01});
    n.item.rad = {s.item.rad[RAD_W-3:0], 2'b00};
    if (wide >= trial) begin
      n.rem  = REM_W'(wide - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = REM_W'(wide);
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== sv/quaternion_smallest_three_decode.sv =====
// Top level of the smallest-three quaternion decoder.
//
// Input channel: a 48-bit packed rotation on in_packed_code is taken at a rising
// edge where start is high and busy is low. Bit 47 is the sign of the dropped
// component, bits 46:45 its index, and three 15-bit fields fill the other three
// components in ascending index order.
// Result channel: out_valid is high for exactly one cycle per beat, with four
// signed components (65536 is 1.0) and out_norm_clamped, which flags a sum of
// squares above one. The receiver cannot stall; results are never held.
// From the accepting edge to the edge that takes the result, a code passes
// through four front stages (midpoint distance, scale, divide, square), the
// queue slot that takes the radicand, a radicand entry register, a 17-stage
// square root and a final output register.
// Throughput is one code per cycle; the square root is fully pipelined, one root
// bit per stage. busy rises only if the queue plus the front pipeline could
// overrun the 8-entry queue; the back part drains one beat every cycle, so busy
// stays low and codes can follow back to back.
// Reset (rst_n low, synchronous) empties every stage and the queue; no result
// beat appears in the cycle after reset.
module quaternion_smallest_three_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [qstd_pkg::CODE_W-1:0]         in_packed_code,
  output logic                                out_valid,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_x,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_y,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_z,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_w,
  output logic                                out_norm_clamped
);
  import qstd_pkg::*;

  qstd_beat_t        push;
  qstd_beat_t        head;
  logic [INFL_W-1:0] inflight;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   credit_used;
  logic              accept;

  // Hold off new beats while queue entries plus in-flight items could fill the queue.
  assign credit_used = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(inflight);
  assign busy        = credit_used >= (QCNT_W + 1)'(QDEPTH);
  assign accept      = start && !busy;

  qstd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .packed_code (in_packed_code),
    .push        (push),
    .inflight    (inflight)
  );

  qstd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .head  (head),
    .count (q_count)
  );

  qstd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_beat          (head),
    .out_valid        (out_valid),
    .out_comp_x       (out_comp_x),
    .out_comp_y       (out_comp_y),
    .out_comp_z       (out_comp_z),
    .out_comp_w       (out_comp_w),
    .out_norm_clamped (out_norm_clamped)
  );

endmodule

// ===== sv/qstd_front.sv =====
// Front part: takes packed codes, scales the three kept fields and forms the radicand.
module qstd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [qstd_pkg::CODE_W-1:0]  packed_code,
  output qstd_pkg::qstd_beat_t         push,
  output logic [qstd_pkg::INFL_W-1:0]  inflight
);
  import qstd_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  qstd_meta_t m1_r, m2_r, m3_r, m4_r;
  logic [NFIELD-1:0][DMAG_W-1:0] dmag_r;
  logic [NFIELD-1:0][PROD_W-1:0] prod_r;
  logic [NFIELD-1:0][QW-1:0]     q_r;
  logic [NFIELD-1:0][QW-1:0]     q4_r;
  logic [NFIELD-1:0][SQ_W-1:0]   sq_r;

  logic [NFIELD-1:0][FIELD_BITS-1:0] fld;
  logic [NFIELD-1:0][DMAG_W-1:0]     dmag_nxt;
  logic [NFIELD-1:0]                 dneg;
  logic [NFIELD-1:0][PROD_W-1:0]     prod_nxt;
  logic [NFIELD-1:0][Y_W-1:0]        y;
  logic [NFIELD-1:0][Q0_W-1:0]       q0;
  logic [NFIELD-1:0][R_W-1:0]        rmd;
  logic [NFIELD-1:0][QW-1:0]         q_nxt;
  logic [SUM_W-1:0]                  sum;
  logic                              clamp;

  // Split the code into fields and take the distance from the midpoint.
  always_comb begin
    for (int k = 0; k < NFIELD; k++) begin
      fld[k]      = packed_code[(NFIELD - 1 - k) * FIELD_BITS +: FIELD_BITS];
      dneg[k]     = fld[k] < FIELD_BITS'(MID);
      dmag_nxt[k] = dneg[k] ? DMAG_W'(FIELD_BITS'(MID) - fld[k])
                            : DMAG_W'(fld[k] - FIELD_BITS'(MID));
    end
  end

  // Multiply by 1/sqrt2 in Q30 and add half the divisor for rounding.
  always_comb begin
    for (int k = 0; k < NFIELD; k++) begin
      prod_nxt[k] = PROD_W'(dmag_r[k]) * PROD_W'(RS2_Q30) + PROD_W'(HALF_D);
    end
  end

  // Divide by the midpoint 2^n-1: quotient by shift, then a small remainder fix-up.
  always_comb begin
    for (int k = 0; k < NFIELD; k++) begin
      y[k]     = prod_r[k][PROD_W-1:SCALE_SH];
      q0[k]    = y[k][Y_W-1:LO_W];
      rmd[k]   = R_W'(q0[k]) + R_W'(y[k][LO_W-1:0]);
      q_nxt[k] = QW'(q0[k]);
      for (int j = 1; j <= CORR_N; j++) begin
        if (longint'(rmd[k]) >= longint'(j) * MID) begin
          q_nxt[k] = q_nxt[k] + QW'(1);
        end
      end
    end
  end

  // Sum of squares, clamp check and radicand for the dropped component.
  always_comb begin
    sum   = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    clamp = CMP_W'(sum) > CMP_W'(ONE_SQ);
    push.valid      = v4_r;
    push.item.kmag  = q4_r;
    push.item.kneg  = m4_r.kneg;
    push.item.drop  = m4_r.drop;
    push.item.sign  = m4_r.sign;
    push.item.clamp = clamp;
    push.item.rad   = clamp ? '0 : RAD_W'(CMP_W'(ONE_SQ) - CMP_W'(sum));
  end

  assign inflight = INFL_W'($countones({v1_r, v2_r, v3_r, v4_r}));

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    m1_r.kneg <= dneg;
    m1_r.drop <= packed_code[INDEX_LSB +: DROP_W];
    m1_r.sign <= packed_code[SIGN_BIT];
    dmag_r    <= dmag_nxt;
    m2_r      <= m1_r;
    prod_r    <= prod_nxt;
    m3_r      <= m2_r;
    q_r       <= q_nxt;
    m4_r      <= m3_r;
    q4_r      <= q_r;
    for (int k = 0; k < NFIELD; k++) begin
      sq_r[k] <= SQ_W'(q_r[k]) * SQ_W'(q_r[k]);
    end
  end

endmodule

// ===== sv/qstd_queue.sv =====
// Short queue that decouples the front part from the square root back part.
module qstd_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qstd_pkg::qstd_beat_t         push,
  output qstd_pkg::qstd_beat_t         head,
  output logic [qstd_pkg::QCNT_W-1:0]  count
);
  import qstd_pkg::*;

  qstd_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  // The back part never stalls, so the head leaves whenever one is present.
  assign pop        = count_r != '0;
  assign head.valid = pop;
  assign head.item  = mem_r[rd_ptr_r];
  assign count      = count_r;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push.valid) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== sv/qstd_back.sv =====
// Back part: pipelined square root, rounding, and placement of the four components.
module qstd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qstd_pkg::qstd_beat_t                in_beat,
  output logic                                out_valid,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_x,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_y,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_z,
  output logic signed [qstd_pkg::OUT_W-1:0]   out_comp_w,
  output logic                                out_norm_clamped
);
  import qstd_pkg::*;

  logic [ISQ_STEPS:0] sv_r;
  qstd_root_t         st_r [ISQ_STEPS+1];

  qstd_root_t               last;
  logic [ROOT_W-1:0]        root_rnd;
  logic [OUT_W-1:0]         dropped;
  logic [NFIELD-1:0][OUT_W-1:0] kv;
  logic [OUT_W-1:0]         cx_nxt, cy_nxt, cz_nxt, cw_nxt;

  logic             out_valid_r;
  logic [OUT_W-1:0] cx_r, cy_r, cz_r, cw_r;
  logic             clamp_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else begin
      sv_r <= {sv_r[ISQ_STEPS-1:0], in_beat.valid};
    end
  end

  // One root digit per stage.
  always_ff @(posedge clk) begin
    st_r[0] <= '{item: in_beat.item, rem: '0, root: '0};
    for (int k = 1; k <= ISQ_STEPS; k++) begin
      st_r[k] <= root_step(st_r[k-1]);
    end
  end

  // Round to nearest, sign everything and route kept fields around the dropped slot.
  always_comb begin
    last     = st_r[ISQ_STEPS];
    root_rnd = (ROOT_W'(last.rem) > last.root && last.rem[REM_W-1:ROOT_W] == '0) ||
               (last.rem[REM_W-1:ROOT_W] != '0) ? last.root + ROOT_W'(1) : last.root;
    dropped  = to_out(root_rnd, last.item.sign);
    for (int k = 0; k < NFIELD; k++) begin
      kv[k] = to_out(ROOT_W'(last.item.kmag[k]), last.item.kneg[k]);
    end
    cx_nxt = (last.item.drop == IDX_X) ? dropped : kv[0];
    cy_nxt = (last.item.drop == IDX_Y) ? dropped :
             (last.item.drop == IDX_X) ? kv[0] : kv[1];
    cz_nxt = (last.item.drop == IDX_Z) ? dropped :
             (last.item.drop == IDX_W) ? kv[2] : kv[1];
    cw_nxt = (last.item.drop == IDX_W) ? dropped : kv[2];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv_r[ISQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    cw_r    <= cw_nxt;
    clamp_r <= last.item.clamp;
  end

  assign out_valid        = out_valid_r;
  assign out_comp_x       = cx_r;
  assign out_comp_y       = cy_r;
  assign out_comp_z       = cz_r;
  assign out_comp_w       = cw_r;
  assign out_norm_clamped = clamp_r;

endmodule

// ===== sv/qstd_check.sv =====
// Port-level checker for the quaternion decoder and its bind to the top level.
module qstd_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [qstd_pkg::OUT_W-1:0]   out_comp_x,
  input logic signed [qstd_pkg::OUT_W-1:0]   out_comp_y,
  input logic signed [qstd_pkg::OUT_W-1:0]   out_comp_z,
  input logic signed [qstd_pkg::OUT_W-1:0]   out_comp_w,
  input logic                                out_norm_clamped
);
  import qstd_pkg::*;

  // Every accepted beat comes out after the fixed latency.
  a_fwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted code produced no result at the expected cycle");

  // No result beat without a matching accepted beat.
  a_bwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result beat without a matching accepted code");

  // A clamped radicand leaves the dropped component at zero.
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_norm_clamped) |->
      (out_comp_x == '0 || out_comp_y == '0 || out_comp_z == '0 || out_comp_w == '0))
    else $error("clamped result has no zero component");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind quaternion_smallest_three_decode qstd_check u_qstd_check (.*);
